@@ rtl/core/mpc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared constants, operation codes and control types of the multiset
// permutation check core.
// ----------------------------------------------------------------------------
package mpc_pkg;

    // Capacity of each element store.
    localparam int MAX_ELEMENTS = 128;
    localparam int ADDR_W       = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
    localparam int DATA_W       = 32;
    localparam int OP_W         = 2;

    // Operation codes carried by a request beat.
    localparam logic [OP_W-1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK       = 2'd2;

    // Sort request from the controller to one store.
    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] len;
    } sort_cmd_t;

endpackage : mpc_pkg
`default_nettype wire

@@ rtl/core/mpc_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_if
// Valid/ready channels of the permutation check core: the request channel
// carrying operation and element, and the result channel.
// ----------------------------------------------------------------------------
interface mpc_req_if;
    logic               valid;
    logic               ready;
    logic [1:0]         operation;
    logic signed [31:0] element_value;

    modport source (output valid, output operation, output element_value, input ready);
    modport sink   (input valid, input operation, input element_value, output ready);
endinterface : mpc_req_if

interface mpc_rsp_if;
    logic valid;
    logic ready;
    logic is_permutation;
    logic overflowed;

    modport source (output valid, output is_permutation, output overflowed, input ready);
    modport sink   (input valid, input is_permutation, input overflowed, output ready);
endinterface : mpc_rsp_if
`default_nettype wire

@@ rtl/core/mpc_store_sort.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpc_store_sort
// One element store in a synchronous RAM with an in-place insertion sorter
// that works through the single read and write ports of the RAM.
// ----------------------------------------------------------------------------
module mpc_store_sort
    import mpc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              ld_en,
    input  wire logic [ADDR_W-1:0] ld_addr,
    input  wire logic [DATA_W-1:0] ld_data,
    input  wire sort_cmd_t         cmd,
    output logic                   busy,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0]      rd_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_GETV  = 4'b0010,
        S_CMP   = 4'b0100,
        S_PLACE = 4'b1000
    } sort_state_t;

    sort_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   i_reg, i_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [ADDR_W-1:0]  j_reg, j_next;
    logic [DATA_W-1:0]  v_reg, v_next;
    logic [CNT_W-1:0]   i_inc;

    logic               s_we;
    logic [ADDR_W-1:0]  s_wa;
    logic [DATA_W-1:0]  s_wd;
    logic [ADDR_W-1:0]  s_ra;

    logic [DATA_W-1:0]  mem [MAX_ELEMENTS];
    logic [DATA_W-1:0]  rd_data_reg;

    assign i_inc   = i_reg + CNT_W'(1);
    assign busy    = (state_reg != S_IDLE);
    assign rd_data = rd_data_reg;

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        v_next     = v_reg;
        len_next   = len_reg;
        s_we       = 1'b0;
        s_wa       = j_reg;
        s_wd       = v_reg;
        s_ra       = rd_addr;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start && (cmd.len > CNT_W'(1)))
                begin
                    len_next   = cmd.len;
                    i_next     = CNT_W'(1);
                    s_ra       = ADDR_W'(1);
                    state_next = S_GETV;
                end
            end
            S_GETV:
            begin
                // The element being inserted has just arrived.
                v_next     = rd_data_reg;
                j_next     = i_reg[ADDR_W-1:0];
                s_ra       = i_reg[ADDR_W-1:0] - ADDR_W'(1);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                s_we = 1'b1;
                if ($signed(rd_data_reg) > $signed(v_reg))
                begin
                    // Shift the larger neighbor up by one place.
                    s_wd   = rd_data_reg;
                    j_next = j_reg - ADDR_W'(1);
                    if (j_reg == ADDR_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        s_ra = j_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    i_next = i_inc;
                    if (i_inc == len_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        s_ra       = i_inc[ADDR_W-1:0];
                        state_next = S_GETV;
                    end
                end
            end
            S_PLACE:
            begin
                s_we   = 1'b1;
                i_next = i_inc;
                if (i_inc == len_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    s_ra       = i_inc[ADDR_W-1:0];
                    state_next = S_GETV;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        v_reg   <= v_next;
        len_reg <= len_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_we || ld_en)
        begin
            mem[s_we ? s_wa : ld_addr] <= s_we ? s_wd : ld_data;
        end
        rd_data_reg <= mem[s_ra];
    end

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ld_en |-> (state_reg == S_IDLE))
        else $error("load write while the sorter owns the store");

    a_scan_above_base: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (j_reg != '0))
        else $error("insertion scan reached below the base entry");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (i_reg < len_reg))
        else $error("insertion index beyond the sort length");

endmodule : mpc_store_sort
`default_nettype wire

@@ rtl/core/multiset_permutation_check_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// multiset_permutation_check_core
// Loads two stores of signed elements and checks whether they hold the same
// multiset, by sorting both in place and comparing them entry by entry.
// ----------------------------------------------------------------------------
// A load beat is accepted one per cycle while no check is in progress.
// A check with equal counts insertion-sorts both stores in parallel (one RAM
// access pair per cycle), then compares them entry by entry and posts the
// result. A check with unequal counts skips the sort and the compare and posts
// a failing result. Reset clears the counts, the overflow flag and the
// handshake state; the store RAMs are not cleared.
// ----------------------------------------------------------------------------
module multiset_permutation_check_core
    import mpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mpc_req_if.sink   request,
    mpc_rsp_if.source result
);

    // The controller walks: idle (taking beats), waiting for both sorters,
    // reading one pair of entries, comparing it, and posting the result.
    typedef enum logic [4:0] {
        T_IDLE = 5'b00001,
        T_SORT = 5'b00010,
        T_RD   = 5'b00100,
        T_EQ   = 5'b01000,
        T_OUT  = 5'b10000
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  first_count_reg, first_count_next;
    logic [CNT_W-1:0]  second_count_reg, second_count_next;
    logic              overflow_reg, overflow_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              same_reg, same_next;
    logic              out_valid_reg;
    logic              out_perm_reg;
    logic              out_ovf_reg;
    logic              out_load;

    logic              accept;
    logic              ld_first_en;
    logic              ld_second_en;
    sort_cmd_t         sort_cmd;
    logic              first_busy;
    logic              second_busy;
    logic [DATA_W-1:0] first_q;
    logic [DATA_W-1:0] second_q;
    logic [CNT_W-1:0]  idx_inc;

    // Beats are taken only while no check is in progress. A finished result
    // sitting in the output register does not hold back loads.
    assign request.ready        = (state_reg == T_IDLE);
    assign accept               = request.valid && request.ready;
    assign idx_inc              = idx_reg + CNT_W'(1);

    assign result.valid          = out_valid_reg;
    assign result.is_permutation = out_perm_reg;
    assign result.overflowed     = out_ovf_reg;

    always_comb
    begin
        state_next        = state_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        overflow_next     = overflow_reg;
        idx_next          = idx_reg;
        same_next         = same_reg;
        ld_first_en       = 1'b0;
        ld_second_en      = 1'b0;
        sort_cmd.start    = 1'b0;
        sort_cmd.len      = first_count_reg;
        out_load          = 1'b0;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    unique case (request.operation)
                        OP_LOAD_FIRST:
                        begin
                            // A full store drops the element and marks overflow.
                            if (first_count_reg < CNT_W'(MAX_ELEMENTS))
                            begin
                                ld_first_en      = 1'b1;
                                first_count_next = first_count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        OP_LOAD_SECOND:
                        begin
                            if (second_count_reg < CNT_W'(MAX_ELEMENTS))
                            begin
                                ld_second_en      = 1'b1;
                                second_count_next = second_count_reg + CNT_W'(1);
                            end
                            else
                            begin
                                overflow_next = 1'b1;
                            end
                        end
                        OP_CHECK:
                        begin
                            if (first_count_reg != second_count_reg)
                            begin
                                // Unequal counts fail at once; nothing is sorted.
                                same_next  = 1'b0;
                                state_next = T_OUT;
                            end
                            else
                            begin
                                sort_cmd.start = 1'b1;
                                same_next      = 1'b1;
                                state_next     = T_SORT;
                            end
                        end
                        default:
                        begin
                            // The unused code is taken and has no effect.
                        end
                    endcase
                end
            end
            T_SORT:
            begin
                if (!first_busy && !second_busy)
                begin
                    idx_next = '0;
                    // Two empty stores are a permutation of each other.
                    state_next = (first_count_reg == '0) ? T_OUT : T_RD;
                end
            end
            T_RD:
            begin
                // The read address follows idx_reg; data is back next cycle.
                state_next = T_EQ;
            end
            T_EQ:
            begin
                if (first_q != second_q)
                begin
                    same_next  = 1'b0;
                    state_next = T_OUT;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = (idx_inc == first_count_reg) ? T_OUT : T_RD;
                end
            end
            T_OUT:
            begin
                // Post the result once the output register is free, then
                // empty both stores and drop the overflow mark.
                if (!out_valid_reg || result.ready)
                begin
                    out_load          = 1'b1;
                    first_count_next  = '0;
                    second_count_next = '0;
                    overflow_next     = 1'b0;
                    state_next        = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= T_IDLE;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            overflow_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            overflow_reg     <= overflow_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        same_reg <= same_next;
        if (out_load)
        begin
            out_perm_reg <= same_reg;
            out_ovf_reg  <= overflow_reg;
        end
    end

    // Both stores take their load address from their own count and are
    // read at the same compare index.
    mpc_store_sort u_first_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ld_en   (ld_first_en),
        .ld_addr (first_count_reg[ADDR_W-1:0]),
        .ld_data (request.element_value),
        .cmd     (sort_cmd),
        .busy    (first_busy),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (first_q)
    );

    mpc_store_sort u_second_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ld_en   (ld_second_en),
        .ld_addr (second_count_reg[ADDR_W-1:0]),
        .ld_data (request.element_value),
        .cmd     (sort_cmd),
        .busy    (second_busy),
        .rd_addr (idx_reg[ADDR_W-1:0]),
        .rd_data (second_q)
    );

    a_compare_equal_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_EQ) |-> (first_count_reg == second_count_reg))
        else $error("compare pass running on stores of unequal count");

    a_sort_assumes_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_SORT) |-> same_reg)
        else $error("sort wait entered with a failed match flag");

    a_no_load_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != T_IDLE) |-> (!ld_first_en && !ld_second_en))
        else $error("store load issued during a check");

    a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (state_reg == T_OUT) && !first_busy && !second_busy)
        else $error("result posted while a sorter is still busy");

endmodule : multiset_permutation_check_core
`default_nettype wire

@@ tb/mpc_verdict_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpc_verdict_checker
// Watches the request and result channels of the permutation check core.
// It keeps its own copy of both element stores and predicts the verdict for
// every accepted check beat. Each returned verdict is compared field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
module mpc_verdict_checker
    import mpc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    mpc_req_if        req_bus,
    mpc_rsp_if        rsp_bus,
    output int        mismatches,
    output int        outstanding
);

    typedef logic signed [DATA_W-1:0] element_list_t[$];

    typedef struct packed {
        logic is_permutation;
        logic overflowed;
    } verdict_t;

    element_list_t first_elems;
    element_list_t second_elems;
    logic          overflow_seen;
    verdict_t      pending_verdicts[$];
    int            error_tally;

    // Two lists hold the same multiset when every value occurs equally often
    // in both. Counting occurrences gives the same answer as sorting and
    // comparing position by position.
    function automatic logic stores_match(input element_list_t a, input element_list_t b);
        int   tally[logic [DATA_W-1:0]];
        logic same;
        same = (a.size() == b.size());
        foreach (a[i])
        begin
            if (tally.exists(a[i]))
                tally[a[i]] = tally[a[i]] + 1;
            else
                tally[a[i]] = 1;
        end
        foreach (b[i])
        begin
            if (tally.exists(b[i]))
                tally[b[i]] = tally[b[i]] - 1;
            else
                same = 1'b0;
        end
        foreach (tally[k])
        begin
            if (tally[k] != 0)
                same = 1'b0;
        end
        return same;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            first_elems.delete();
            second_elems.delete();
            pending_verdicts.delete();
            overflow_seen = 1'b0;
            error_tally   = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Results first, so a verdict that leaves at the same edge as a new
            // check arrives is never matched against that new check.
            if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("unexpected result beat: is_permutation %0b, overflowed %0b",
                           rsp_bus.is_permutation, rsp_bus.overflowed);
                    error_tally++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (rsp_bus.is_permutation !== want.is_permutation)
                    begin
                        $error("is_permutation mismatch: expected %0b, actual %0b",
                               want.is_permutation, rsp_bus.is_permutation);
                        error_tally++;
                    end
                    if (rsp_bus.overflowed !== want.overflowed)
                    begin
                        $error("overflowed mismatch: expected %0b, actual %0b",
                               want.overflowed, rsp_bus.overflowed);
                        error_tally++;
                    end
                end
            end

            if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            begin
                case (req_bus.operation)
                    OP_LOAD_FIRST:
                    begin
                        if (first_elems.size() < MAX_ELEMENTS)
                            first_elems.push_back(req_bus.element_value);
                        else
                            overflow_seen = 1'b1;
                    end
                    OP_LOAD_SECOND:
                    begin
                        if (second_elems.size() < MAX_ELEMENTS)
                            second_elems.push_back(req_bus.element_value);
                        else
                            overflow_seen = 1'b1;
                    end
                    OP_CHECK:
                    begin
                        want.is_permutation = stores_match(first_elems, second_elems);
                        want.overflowed     = overflow_seen;
                        pending_verdicts.push_back(want);
                        first_elems.delete();
                        second_elems.delete();
                        overflow_seen = 1'b0;
                    end
                    default: ;
                endcase
            end

            mismatches  <= error_tally;
            outstanding <= pending_verdicts.size();
        end
    end

endmodule : mpc_verdict_checker

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the multiset permutation check core. A short
// directed part covers empty stores, extreme values, repeated values, unequal
// counts and the unused operation code; a random part then sends well-formed
// load/load/check sequences with shuffled and sometimes corrupted content,
// mixed with noise, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb
    import mpc_pkg::*;
();

    // Operation code the core must ignore; the package names only the used ones.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1450;
    // The slowest check (two full stores of 128) moves no beat on either channel
    // while it runs; the limit leaves a wide margin over it.
    localparam int WATCHDOG_LIMIT = 40000;
    // Loads produce no result beat, so a short tail is enough at the end.
    localparam int DRAIN_CYCLES   = 32;

    logic clk;
    logic rst_n;

    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int mismatches;
    int outstanding;
    int quiet_cycles;

    mpc_req_if req_bus();
    mpc_rsp_if rsp_bus();

    multiset_permutation_check_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_bus),
        .result  (rsp_bus)
    );

    mpc_verdict_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_bus     (req_bus),
        .rsp_bus     (rsp_bus),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 10 ns clock, low for the first half period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The result side is ready on every cycle unless the current phase asks
    // for stalls. This process is the only driver of the ready line.
    initial
    begin
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // The watchdog only counts cycles in which no beat moves on either
    // channel, so a long run is fine as long as it keeps making progress.
    // The counter starts from zero as every int does.
    always @(posedge clk)
    begin
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Element values favor the two extremes, zero, all ones and a small pool
    // of values, so that duplicates and sign boundaries show up often.
    function automatic logic [DATA_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return {DATA_W{1'b1}};
            3:       return '0;
            4, 5, 6: return DATA_W'($urandom_range(0, 7)) - DATA_W'(4);
            default: return $urandom;
        endcase
    endfunction

    // Sends one request beat and returns at the edge where it is accepted.
    // Valid stays high on return, so a back-to-back beat only swaps the
    // payload; an idle gap lowers valid in a later time step.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid         <= 1'b1;
        req_bus.operation     <= op;
        req_bus.element_value <= value;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    // Holds the request channel idle until every predicted verdict has come
    // back. At least one edge passes, so valid never sees two updates in one
    // time step.
    task automatic pause_until_drained();
        req_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin : stimulus
        logic signed [DATA_W-1:0] lhs[$];
        logic signed [DATA_W-1:0] rhs[$];
        logic signed [DATA_W-1:0] swap;
        int n;
        int k;
        int j;
        int li;
        int ri;
        int seq_count;
        int big_sets;
        int random_start;

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;

        rst_n                 <= 1'b0;
        req_bus.valid         <= 1'b0;
        req_bus.operation     <= OP_LOAD_FIRST;
        req_bus.element_value <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Two empty stores count as a match.
        send_beat(OP_CHECK, '0);

        // The most negative value on both sides.
        send_beat(OP_LOAD_FIRST, 32'h8000_0000);
        send_beat(OP_LOAD_SECOND, 32'h8000_0000);
        send_beat(OP_CHECK, '0);

        // Most positive and minus one, loaded in opposite orders.
        send_beat(OP_LOAD_FIRST, 32'h7FFF_FFFF);
        send_beat(OP_LOAD_FIRST, 32'hFFFF_FFFF);
        send_beat(OP_LOAD_SECOND, 32'hFFFF_FFFF);
        send_beat(OP_LOAD_SECOND, 32'h7FFF_FFFF);
        send_beat(OP_CHECK, 32'h1234_5678);

        // The unused code must change nothing; the counts then differ.
        send_beat(OP_UNUSED, 32'h5A5A_A5A5);
        send_beat(OP_LOAD_FIRST, 32'd5);
        send_beat(OP_CHECK, '0);

        // Equal counts but different content. The check value is ignored.
        send_beat(OP_LOAD_FIRST, 32'd0);
        send_beat(OP_LOAD_SECOND, 32'd1);
        send_beat(OP_CHECK, 32'hFFFF_FFFF);

        // Same set of values with different multiplicities.
        send_beat(OP_LOAD_FIRST, 32'd7);
        send_beat(OP_LOAD_FIRST, 32'd7);
        send_beat(OP_LOAD_FIRST, 32'hFFFF_FFFD);
        send_beat(OP_LOAD_SECOND, 32'd7);
        send_beat(OP_LOAD_SECOND, 32'hFFFF_FFFD);
        send_beat(OP_LOAD_SECOND, 32'hFFFF_FFFD);
        send_beat(OP_CHECK, '0);

        // Random part. Every twelfth sequence the sender waits for all verdicts to
        // return and the idle and stall pattern moves on to the next phase.
        seq_count    = 0;
        big_sets     = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (seq_count % 12 == 0)
            begin
                pause_until_drained();
                case ((seq_count / 12) % 4)
                    0:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 0;
                    end
                    1:
                    begin
                        send_idle_pct  = 56;
                        recv_stall_pct = 0;
                    end
                    2:
                    begin
                        send_idle_pct  = 0;
                        recv_stall_pct = 56;
                    end
                    default:
                    begin
                        send_idle_pct  = 16;
                        recv_stall_pct = 16;
                    end
                endcase
            end
            seq_count++;

            if ($urandom_range(0, 99) < 15)
            begin
                // Noise: any operation, any value, in no particular order.
                n = $urandom_range(1, 8);
                repeat (n) send_beat(OP_W'($urandom_range(0, 3)), random_element());
            end
            else
            begin
                // A well-formed sequence. Most sets are small to keep the
                // quadratic sort short; a few come near a full store or spill over it.
                if (seq_count % 40 == 39 && big_sets < 3)
                begin
                    n = 126 + $urandom_range(0, 6);
                    big_sets++;
                end
                else
                begin
                    n = $urandom_range(0, 12);
                end
                lhs.delete();
                repeat (n) lhs.push_back(random_element());

                // The second set starts as a shuffled copy of the first.
                rhs = lhs;
                for (k = rhs.size() - 1; k > 0; k--)
                begin
                    j      = $urandom_range(0, k);
                    swap   = rhs[k];
                    rhs[k] = rhs[j];
                    rhs[j] = swap;
                end

                // Then it is sometimes broken: a flipped bit, a missing or
                // extra element, or one value repeated in place of another.
                case ($urandom_range(0, 7))
                    0:
                    begin
                        if (rhs.size() > 0)
                        begin
                            k      = $urandom_range(0, rhs.size() - 1);
                            rhs[k] = rhs[k] ^ (32'h1 << $urandom_range(0, 31));
                        end
                    end
                    1:
                    begin
                        if (rhs.size() > 0)
                            rhs.delete($urandom_range(0, rhs.size() - 1));
                    end
                    2:
                    begin
                        rhs.push_back(random_element());
                    end
                    3:
                    begin
                        if (rhs.size() > 1)
                        begin
                            k      = $urandom_range(0, rhs.size() - 1);
                            j      = $urandom_range(0, rhs.size() - 1);
                            rhs[k] = rhs[j];
                        end
                    end
                    default: ;
                endcase

                // Loads to the two stores are interleaved at random, with an
                // occasional ignored beat in between.
                li = 0;
                ri = 0;
                while (li < lhs.size() || ri < rhs.size())
                begin
                    if ($urandom_range(0, 39) == 0)
                        send_beat(OP_UNUSED, random_element());
                    if (ri >= rhs.size() || (li < lhs.size() && $urandom_range(0, 1) == 0))
                    begin
                        send_beat(OP_LOAD_FIRST, lhs[li]);
                        li++;
                    end
                    else
                    begin
                        send_beat(OP_LOAD_SECOND, rhs[ri]);
                        ri++;
                    end
                end
                send_beat(OP_CHECK, random_element());
            end
        end

        // Let every outstanding verdict come back, then give the core a short
        // tail in which any stray result would still be caught.
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule : tb

@@ filelist.f @@
rtl/core/mpc_pkg.sv
rtl/core/mpc_if.sv
rtl/core/mpc_store_sort.sv
rtl/core/multiset_permutation_check_core.sv
tb/mpc_verdict_checker.sv
tb/tb.sv
